[sv/cale_pkg.sv]
// cale_pkg: shared constants, request codes and controller/datapath structs
// for the cursor array list engine. No dependencies.

package cale_pkg;

	localparam int FUNC_W = 4;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 11;

	localparam logic [FUNC_W-1:0] FN_CLEAR  = 4'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 4'd1;
	localparam logic [FUNC_W-1:0] FN_APPEND = 4'd2;
	localparam logic [FUNC_W-1:0] FN_START  = 4'd3;
	localparam logic [FUNC_W-1:0] FN_END    = 4'd4;
	localparam logic [FUNC_W-1:0] FN_PREV   = 4'd5;
	localparam logic [FUNC_W-1:0] FN_NEXT   = 4'd6;
	localparam logic [FUNC_W-1:0] FN_MOVE   = 4'd7;
	localparam logic [FUNC_W-1:0] FN_READ   = 4'd8;
	localparam logic [FUNC_W-1:0] FN_DELETE = 4'd9;

	// controller -> datapath
	typedef struct packed {
		logic quick;   // request done without shift or read: update state, load result
		logic start;   // capture request, set up shift or read
		logic step;    // one shift read (and write of previous read)
		logic drain;   // write back last shifted entry
		logic finish;  // close insert, delete or read, load result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic long_ins;  // insert needing tail shift up
		logic long_del;  // delete needing tail shift down
		logic rd_ok;     // read that succeeds
		logic last;      // current shift read is the final one
	} stat_t;

endpackage

[sv/cale_ram.sv]
// cale_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.

module cale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/cale_ctrl.sv]
// cale_ctrl: request sequencer of the cursor array list engine.
// Depends on cale_pkg; drives cale_dp through cmd_t, observes stat_t.

module cale_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  cale_pkg::stat_t stat,
	output cale_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (stat.long_ins || stat.long_del) begin
						cmd.start = 1'b1;
						state_d   = ST_SHIFT;
					end else if (stat.rd_ok) begin
						cmd.start = 1'b1;
						state_d   = ST_FIN;
					end else begin
						cmd.quick = 1'b1;
					end
				end
			end
			ST_SHIFT: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.drain = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (out_valid_q && !out_ready) || cmd.quick || cmd.finish;
		end
	end

endmodule

[sv/cale_dp.sv]
// cale_dp: list state, entry RAM, shift pipeline and result register.
// Depends on cale_pkg and cale_ram; commanded by cale_ctrl.

module cale_dp #(
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cale_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic [cale_pkg::FUNC_W-1:0]    in_func,
	input  logic signed [cale_pkg::VAL_W-1:0] in_value,
	input  logic [cale_pkg::CNT_W-1:0]     in_position,
	input  cale_pkg::cmd_t                 cmd,
	output cale_pkg::stat_t                stat,
	output logic                           out_ok,
	output logic signed [cale_pkg::VAL_W-1:0] out_read_value,
	output logic [cale_pkg::CNT_W-1:0]     out_list_length,
	output logic [cale_pkg::CNT_W-1:0]     out_cursor_pos
);

	localparam int CW = cale_pkg::CNT_W;
	localparam int VW = cale_pkg::VAL_W;

	logic [CW-1:0] count_q, cursor_q, cap_q;
	logic [cale_pkg::FUNC_W-1:0] func_q;
	logic [VW-1:0] val_q;
	logic [AW-1:0] rd_addr_q, end_q, addr_s1;
	logic          pend_s1, up_q;

	logic          full, cur_lt, rd_ok, del_ok;
	logic [CW-1:0] cnt_m1;

	logic          q_ok, q_we;
	logic [CW-1:0] q_cnt, q_cur;
	logic [AW-1:0] q_waddr;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [VW-1:0] mem_wdata, mem_rdata;

	assign full   = (count_q >= cap_q) || (32'(count_q) >= 32'(DEPTH));
	assign cur_lt = cursor_q < count_q;
	assign rd_ok  = cur_lt && (32'(cursor_q) < 32'(DEPTH));
	assign del_ok = cur_lt && (32'(count_q) <= 32'(DEPTH));
	assign cnt_m1 = count_q - CW'(1);

	assign stat.long_ins = (in_func == cale_pkg::FN_INSERT) && !full && cur_lt;
	assign stat.long_del = (in_func == cale_pkg::FN_DELETE) && del_ok && (cursor_q != cnt_m1);
	assign stat.rd_ok    = (in_func == cale_pkg::FN_READ) && rd_ok;
	assign stat.last     = rd_addr_q == end_q;

	// combinational outcome of the offered request, applied by a quick command
	always_comb begin
		q_ok    = 1'b0;
		q_cnt   = count_q;
		q_cur   = cursor_q;
		q_we    = 1'b0;
		q_waddr = AW'(count_q);
		case (in_func)
			cale_pkg::FN_CLEAR: begin
				q_ok  = 1'b1;
				q_cnt = '0;
				q_cur = '0;
			end
			cale_pkg::FN_INSERT: begin
				if (!full) begin
					q_ok    = 1'b1;
					q_cnt   = count_q + CW'(1);
					q_we    = 1'b1;
					q_waddr = AW'(cursor_q);
				end
			end
			cale_pkg::FN_APPEND: begin
				if (!full) begin
					q_ok  = 1'b1;
					q_cur = count_q;
					q_cnt = count_q + CW'(1);
					q_we  = 1'b1;
				end
			end
			cale_pkg::FN_START: begin
				q_ok  = 1'b1;
				q_cur = '0;
			end
			cale_pkg::FN_END: begin
				q_ok  = 1'b1;
				q_cur = count_q;
			end
			cale_pkg::FN_PREV: begin
				if (cursor_q != '0) begin
					q_ok  = 1'b1;
					q_cur = cursor_q - CW'(1);
				end
			end
			cale_pkg::FN_NEXT: begin
				if (cur_lt) begin
					q_ok  = 1'b1;
					q_cur = cursor_q + CW'(1);
				end
			end
			cale_pkg::FN_MOVE: begin
				if (in_position <= count_q) begin
					q_ok  = 1'b1;
					q_cur = in_position;
				end
			end
			cale_pkg::FN_DELETE: begin
				if (del_ok) begin
					q_ok  = 1'b1;
					q_cnt = cnt_m1;
				end
			end
			default: begin
				q_ok = 1'b0;
			end
		endcase
	end

	// RAM port selection
	always_comb begin
		mem_raddr = cmd.step ? rd_addr_q : AW'(cursor_q);
		mem_we    = 1'b0;
		mem_waddr = q_waddr;
		mem_wdata = in_value;
		if ((cmd.step && pend_s1) || cmd.drain) begin
			mem_we    = 1'b1;
			mem_waddr = up_q ? addr_s1 + AW'(1) : addr_s1 - AW'(1);
			mem_wdata = mem_rdata;
		end else if (cmd.finish && (func_q == cale_pkg::FN_INSERT)) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(cursor_q);
			mem_wdata = val_q;
		end else if (cmd.quick) begin
			mem_we = q_we;
		end
	end

	cale_ram #(
		.WIDTH(VW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			cap_q    <= CW'(1024);
			pend_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.quick) begin
				count_q  <= q_cnt;
				cursor_q <= q_cur;
			end
			if (cmd.start || cmd.drain) begin
				pend_s1 <= 1'b0;
			end else if (cmd.step) begin
				pend_s1 <= 1'b1;
			end
			if (cmd.finish) begin
				case (func_q)
					cale_pkg::FN_INSERT: count_q <= count_q + CW'(1);
					cale_pkg::FN_DELETE: count_q <= cnt_m1;
					default:             count_q <= count_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= in_func;
			val_q  <= in_value;
			if (stat.long_ins) begin
				rd_addr_q <= AW'(cnt_m1);
				end_q     <= AW'(cursor_q);
				up_q      <= 1'b1;
			end else begin
				rd_addr_q <= AW'(cursor_q) + AW'(1);
				end_q     <= AW'(cnt_m1);
				up_q      <= 1'b0;
			end
		end
		if (cmd.step) begin
			rd_addr_q <= up_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
			addr_s1   <= rd_addr_q;
		end
		if (cmd.quick) begin
			out_ok          <= q_ok;
			out_read_value  <= '0;
			out_list_length <= q_cnt;
			out_cursor_pos  <= q_cur;
		end
		if (cmd.finish) begin
			out_ok         <= 1'b1;
			out_cursor_pos <= cursor_q;
			case (func_q)
				cale_pkg::FN_INSERT: begin
					out_read_value  <= '0;
					out_list_length <= count_q + CW'(1);
				end
				cale_pkg::FN_DELETE: begin
					out_read_value  <= '0;
					out_list_length <= cnt_m1;
				end
				default: begin
					out_read_value  <= mem_rdata;
					out_list_length <= count_q;
				end
			endcase
		end
	end

endmodule

[sv/cursor_array_list_engine.sv]
// cursor_array_list_engine: top level of the cursor array list engine.
// Depends on cale_pkg, cale_ctrl, cale_dp (which holds cale_ram).
//
//   channel | handshake         | contents
//   s_*     | tvalid/tready     | request item: func, value, position
//   m_*     | tvalid/tready     | result item: ok, read_value, list_length, cursor_pos
//   cfg_*   | write enable only | capacity_limit
//
// Done in IDLE alone: clear, moves, append, refused requests and inserts at
// the end or deletes of the last entry. A read goes on to FIN; an insert or delete
// that moves tail entries steps SHIFT, DRAIN, FIN, bounded by the single RAM write port.
// Reset: asynchronous, clears length, cursor and capacity (1024); the RAM is not cleared.
// A request is taken once the previous result is gone or is being taken.

module cursor_array_list_engine #(
	parameter int DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // func[3:0], value[35:4], position[46:36], zero[47]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // ok[0], read_value[32:1], list_length[43:33],
	                               // cursor_pos[54:44], zero[55]
);

	cale_pkg::cmd_t  cmd;
	cale_pkg::stat_t stat;

	logic                             out_ok;
	logic signed [cale_pkg::VAL_W-1:0] out_read_value;
	logic [cale_pkg::CNT_W-1:0]       out_list_length, out_cursor_pos;

	cale_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cale_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_func        (s_tdata[3:0]),
		.in_value       (s_tdata[35:4]),
		.in_position    (s_tdata[46:36]),
		.cmd            (cmd),
		.stat           (stat),
		.out_ok         (out_ok),
		.out_read_value (out_read_value),
		.out_list_length(out_list_length),
		.out_cursor_pos (out_cursor_pos)
	);

	assign m_tdata = {1'b0, out_cursor_pos, out_list_length, out_read_value, out_ok};

	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.quick, cmd.start, cmd.step, cmd.drain, cmd.finish}))
		else $error("more than one datapath command at once");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("finished request produced no result");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[54:44] <= m_tdata[43:33]))
		else $error("cursor beyond list length");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == 32'd0))
		else $error("refused request carries read data");

endmodule
